// ===== sv/rpt_pkg.sv =====
package rpt_pkg;

   localparam logic [3:0] MODE_TOP       = 4'd0;
   localparam logic [3:0] MODE_ESC       = 4'd1;
   localparam logic [3:0] MODE_STR       = 4'd2;
   localparam logic [3:0] MODE_STR_ESC   = 4'd3;
   localparam logic [3:0] MODE_CLS       = 4'd4;
   localparam logic [3:0] MODE_CLS_ESC   = 4'd5;
   localparam logic [3:0] MODE_RNG_HIGH  = 4'd6;
   localparam logic [3:0] MODE_RNG_AFTER = 4'd7;
   localparam logic [3:0] MODE_NAME      = 4'd8;

   localparam logic [2:0] KIND_CHAR  = 3'd0;
   localparam logic [2:0] KIND_SYM   = 3'd1;
   localparam logic [2:0] KIND_SCHAR = 3'd2;
   localparam logic [2:0] KIND_SEND  = 3'd3;
   localparam logic [2:0] KIND_WORD  = 3'd4;
   localparam logic [2:0] KIND_NCHAR = 3'd5;
   localparam logic [2:0] KIND_DEND  = 3'd6;
   localparam logic [2:0] KIND_SEP   = 3'd7;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_NO_SINGLE  = 3'd1;
   localparam logic [2:0] ERR_NOT_ABOVE  = 3'd2;
   localparam logic [2:0] ERR_NOT_CLOSED = 3'd3;
   localparam logic [2:0] ERR_NAME_OPEN  = 3'd4;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_VT        = 8'h0B;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_BEL       = 8'h07;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_APOS      = 8'h27;
   localparam logic [7:0] CH_DASH      = 8'h2D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_QUESTION  = 8'h3F;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_UNDERLINE = 8'h5F;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_A_LOW     = 8'h61;
   localparam logic [7:0] CH_B_LOW     = 8'h62;
   localparam logic [7:0] CH_F_LOW     = 8'h66;
   localparam logic [7:0] CH_N_LOW     = 8'h6E;
   localparam logic [7:0] CH_R_LOW     = 8'h72;
   localparam logic [7:0] CH_T_LOW     = 8'h74;
   localparam logic [7:0] CH_V_LOW     = 8'h76;

   // one request's worth of work for the back part
   typedef struct packed {
      logic       pre_valid;
      logic [2:0] pre_kind;
      logic [2:0] pre_err;
      logic       words_valid;
      logic [2:0] words_err;
      logic       post_valid;
      logic [2:0] post_kind;
      logic [7:0] post_value;
      logic       clear;
      logic       add_valid;
      logic [7:0] add_lo;
      logic [7:0] add_hi;
   } cmd_type;

   function automatic logic is_name_char(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || c == CH_UNDERLINE;
   endfunction

   // {valid, byte}; unknown escapes are dropped
   function automatic logic [8:0] str_escape(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         CH_N_LOW:     r = {1'b1, CH_LF};
         CH_R_LOW:     r = {1'b1, CH_CR};
         CH_ZERO:      r = {1'b1, CH_NUL};
         CH_T_LOW:     r = {1'b1, CH_TAB};
         CH_V_LOW:     r = {1'b1, CH_VT};
         CH_B_LOW:     r = {1'b1, CH_BS};
         CH_F_LOW:     r = {1'b1, CH_FF};
         CH_A_LOW:     r = {1'b1, CH_BEL};
         CH_QUOTE:     r = {1'b1, CH_QUOTE};
         CH_APOS:      r = {1'b1, CH_APOS};
         CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
         CH_QUESTION:  r = {1'b1, CH_QUESTION};
         default:      r = {1'b0, CH_NUL};
      endcase
      return r;
   endfunction

   function automatic logic [7:0] cls_escape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CH_N_LOW: r = CH_LF;
         CH_R_LOW: r = CH_CR;
         CH_ZERO:  r = CH_NUL;
         CH_T_LOW: r = CH_TAB;
         CH_V_LOW: r = CH_VT;
         CH_F_LOW: r = CH_FF;
         default:  r = c;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/rpt_front.sv =====
module rpt_front import rpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] ch,
   output cmd_type    cmd
);

   logic [3:0] mode_ff, mode_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] low_ff, low_in;
   logic [2:0] err_ff, err_in;

   logic       do_top;
   logic [7:0] top_c;
   logic       add_req;
   logic [7:0] add_b;
   logic       flag_req;
   logic [2:0] flag_code;
   logic [8:0] sdec;

   always_comb begin
      cmd       = '0;
      mode_in   = mode_ff;
      count_in  = count_ff;
      low_in    = low_ff;
      err_in    = err_ff;
      do_top    = 1'b0;
      top_c     = ch;
      add_req   = 1'b0;
      add_b     = ch;
      flag_req  = 1'b0;
      flag_code = ERR_NONE;
      sdec      = str_escape(ch);

      case (mode_ff)
         MODE_ESC: begin
            mode_in        = MODE_TOP;
            cmd.post_valid = 1'b1;
            cmd.post_kind  = KIND_SYM;
            cmd.post_value = ch;
         end
         MODE_STR: begin
            if (ch == CH_NUL) begin
               cmd.pre_valid = 1'b1;
               cmd.pre_kind  = KIND_SEND;
               do_top        = 1'b1;
            end else if (ch == CH_QUOTE) begin
               cmd.pre_valid = 1'b1;
               cmd.pre_kind  = KIND_SEND;
               mode_in       = MODE_TOP;
            end else if (ch == CH_BACKSLASH) begin
               mode_in = MODE_STR_ESC;
            end else begin
               cmd.post_valid = 1'b1;
               cmd.post_kind  = KIND_SCHAR;
               cmd.post_value = ch;
            end
         end
         MODE_STR_ESC: begin
            if (ch == CH_NUL) begin
               cmd.pre_valid = 1'b1;
               cmd.pre_kind  = KIND_SEND;
               do_top        = 1'b1;
            end else begin
               mode_in        = MODE_STR;
               cmd.post_valid = sdec[8];
               cmd.post_kind  = KIND_SCHAR;
               cmd.post_value = sdec[7:0];
            end
         end
         MODE_CLS: begin
            if (ch == CH_NUL) begin
               cmd.words_valid = 1'b1;
               do_top          = 1'b1;
            end else if (ch == CH_RBRACKET) begin
               cmd.words_valid = 1'b1;
               mode_in         = MODE_TOP;
            end else if (ch == CH_DASH) begin
               if (count_ff != 2'd1) begin
                  flag_req  = 1'b1;
                  flag_code = ERR_NO_SINGLE;
                  add_req   = 1'b1;
               end else begin
                  mode_in = MODE_RNG_HIGH;
               end
            end else if (ch == CH_BACKSLASH) begin
               mode_in = MODE_CLS_ESC;
            end else begin
               add_req = 1'b1;
            end
         end
         MODE_CLS_ESC: begin
            if (ch == CH_NUL) begin
               cmd.words_valid = 1'b1;
               do_top          = 1'b1;
            end else begin
               mode_in = MODE_CLS;
               add_req = 1'b1;
               add_b   = cls_escape(ch);
            end
         end
         MODE_RNG_HIGH: begin
            if (ch == CH_NUL) begin
               cmd.words_valid = 1'b1;
               do_top          = 1'b1;
            end else begin
               mode_in = MODE_RNG_AFTER;
               if (ch > low_ff) begin
                  cmd.add_valid = 1'b1;
                  cmd.add_lo    = low_ff + 8'd1;
                  cmd.add_hi    = ch;
                  count_in      = 2'd2;
               end else begin
                  flag_req  = 1'b1;
                  flag_code = ERR_NOT_ABOVE;
               end
            end
         end
         MODE_RNG_AFTER: begin
            if (ch == CH_RBRACKET) begin
               cmd.words_valid = 1'b1;
               mode_in         = MODE_TOP;
            end else if (ch == CH_NUL) begin
               flag_req        = 1'b1;
               flag_code       = ERR_NOT_CLOSED;
               cmd.words_valid = 1'b1;
               do_top          = 1'b1;
            end else begin
               flag_req  = 1'b1;
               flag_code = ERR_NOT_CLOSED;
               if (ch == CH_BACKSLASH) begin
                  mode_in = MODE_CLS_ESC;
               end else begin
                  mode_in = MODE_CLS;
                  add_req = 1'b1;
               end
            end
         end
         MODE_NAME: begin
            if (is_name_char(ch)) begin
               cmd.post_valid = 1'b1;
               cmd.post_kind  = KIND_NCHAR;
               cmd.post_value = ch;
            end else if (ch == CH_RBRACE) begin
               cmd.pre_valid = 1'b1;
               cmd.pre_kind  = KIND_DEND;
               mode_in       = MODE_TOP;
            end else begin
               cmd.pre_valid = 1'b1;
               cmd.pre_kind  = KIND_DEND;
               cmd.pre_err   = ERR_NAME_OPEN;
               do_top        = 1'b1;
               top_c         = ch;
            end
         end
         default: begin
            do_top = 1'b1;
         end
      endcase

      if (do_top && cmd.pre_valid && cmd.pre_kind == KIND_SEND) begin
         top_c = CH_NUL;
      end
      if (do_top && cmd.words_valid) begin
         top_c = CH_NUL;
      end

      if (flag_req && err_ff == ERR_NONE) begin
         err_in = flag_code;
      end

      if (add_req) begin
         if (flag_code == ERR_NO_SINGLE && flag_req) begin
            add_b = CH_DASH;
         end
         cmd.add_valid = 1'b1;
         cmd.add_lo    = add_b;
         cmd.add_hi    = add_b;
         if (count_ff == 2'd0) begin
            low_in   = add_b;
            count_in = 2'd1;
         end else if (count_ff == 2'd1 && add_b != low_ff) begin
            count_in = 2'd2;
         end
      end

      if (do_top) begin
         mode_in = MODE_TOP;
         if (top_c == CH_SPACE || top_c == CH_TAB || top_c == CH_LF || top_c == CH_NUL) begin
            cmd.post_valid = 1'b1;
            cmd.post_kind  = KIND_SEP;
            cmd.post_value = CH_DOLLAR;
         end else if (top_c == CH_QUOTE) begin
            mode_in = MODE_STR;
         end else if (top_c == CH_LBRACKET) begin
            cmd.clear = 1'b1;
            count_in  = 2'd0;
            err_in    = ERR_NONE;
            mode_in   = MODE_CLS;
         end else if (top_c == CH_LBRACE) begin
            mode_in = MODE_NAME;
         end else if (top_c == CH_BACKSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            cmd.post_valid = 1'b1;
            cmd.post_kind  = KIND_CHAR;
            cmd.post_value = top_c;
         end
      end

      cmd.words_err = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TOP;
         count_ff <= 2'd0;
         low_ff   <= 8'd0;
         err_ff   <= ERR_NONE;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         low_ff   <= low_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== sv/rpt_queue.sv =====
module rpt_queue import rpt_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    head_valid
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/rpt_back.sv =====
module rpt_back import rpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     head,
   input  logic        head_valid,
   output logic        head_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_kind,
   output logic [63:0] rsp_value,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last,
   output logic [2:0]  rsp_error_code
);

   localparam logic [2:0] STEP_PRE  = 3'd0;
   localparam logic [2:0] STEP_W0   = 3'd1;
   localparam logic [2:0] STEP_W3   = 3'd4;
   localparam logic [2:0] STEP_POST = 3'd5;

   logic [63:0] bitmap_ff [4];
   logic [2:0]  phase_ff, phase_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [63:0] value_ff, value_in;
   logic [1:0]  widx_ff, widx_in;
   logic        last_ff, last_in;
   logic [2:0]  err_ff, err_in;

   logic [5:0]  present, avail, rest;
   logic [2:0]  cur;
   logic [1:0]  wsel;
   logic        advance, emit;

   always_comb begin
      present = {head.post_valid, {4{head.words_valid}}, head.pre_valid};
      for (int i = 0; i < 6; i++) begin
         avail[i] = present[i] && (3'(i) >= phase_ff);
      end
      cur = STEP_POST;
      for (int i = 5; i >= 0; i--) begin
         if (avail[i]) begin
            cur = 3'(i);
         end
      end
      rest    = avail & (avail - 6'd1);
      wsel    = 2'(cur - STEP_W0);
      advance = head_valid && (!out_valid_ff || rsp_pop);
      emit    = advance && (avail != '0);
      head_pop = advance && (rest == '0);

      phase_in = phase_ff;
      if (advance) begin
         phase_in = (rest == '0) ? STEP_PRE : cur + 3'd1;
      end

      kind_in  = kind_ff;
      value_in = value_ff;
      widx_in  = widx_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         last_in      = (rest == '0);
         if (cur == STEP_PRE) begin
            kind_in  = head.pre_kind;
            value_in = '0;
            widx_in  = '0;
            err_in   = head.pre_err;
         end else if (cur >= STEP_W0 && cur <= STEP_W3) begin
            kind_in  = KIND_WORD;
            value_in = bitmap_ff[wsel];
            widx_in  = wsel;
            err_in   = head.words_err;
         end else begin
            kind_in  = head.post_kind;
            value_in = {56'd0, head.post_value};
            widx_in  = '0;
            err_in   = ERR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= STEP_PRE;
         out_valid_ff <= 1'b0;
         for (int w = 0; w < 4; w++) begin
            bitmap_ff[w] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (head_pop) begin
            for (int w = 0; w < 4; w++) begin
               for (int b = 0; b < 64; b++) begin
                  if (head.clear) begin
                     bitmap_ff[w][b] <= 1'b0;
                  end else if (head.add_valid && 8'(w * 64 + b) >= head.add_lo &&
                               8'(w * 64 + b) <= head.add_hi) begin
                     bitmap_ff[w][b] <= 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      widx_ff  <= widx_in;
      last_ff  <= last_in;
      err_ff   <= err_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_value      = value_ff;
   assign rsp_word_index = widx_ff;
   assign rsp_last       = last_ff;
   assign rsp_error_code = err_ff;

endmodule

// ===== sv/regex_pattern_tokenizer_core.sv =====
// Pattern tokenizer: takes one pattern byte per cycle and returns its tokens in
// order. Most bytes give zero or one token; a string or name cut short gives up
// to two, and a class close gives four class words (five when the input ends
// inside the class). The back part's sequencer sends one token per cycle while
// results are popped, a byte with no tokens still taking its turn; a queue of
// QUEUE_DEPTH requests between the lexer and the sequencer soaks up these
// bursts, so the input stays at one byte per cycle while the queue has room.
// A byte's tokens pass through the queue, then the output registers. The bitmap
// of a class is kept in flip-flops and cleared by reset and at every '['.
module regex_pattern_tokenizer_core import rpt_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_ch,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_kind,
   output logic [63:0] rsp_value,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last,
   output logic [2:0]  rsp_error_code
);

   cmd_type front_cmd;
   cmd_type head;
   logic    head_valid;
   logic    head_pop;
   logic    accept;

   assign accept = req_push && !req_full;

   rpt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_ch),
      .cmd    (front_cmd)
   );

   rpt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_data  (front_cmd),
      .full       (req_full),
      .pop        (head_pop),
      .head       (head),
      .head_valid (head_valid)
   );

   rpt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (head_valid),
      .head_pop       (head_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last),
      .rsp_error_code (rsp_error_code)
   );

   // quarter number only on class words
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_kind != KIND_WORD |-> rsp_word_index == 2'd0)
      else $error("word index set on a non-class token");

   // error codes only on class words and definition ends
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_error_code != ERR_NONE |->
         rsp_kind == KIND_WORD || rsp_kind == KIND_DEND)
      else $error("error code on a token that cannot carry one");

   // a name-unclosed code belongs to a definition end
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_error_code == ERR_NAME_OPEN |-> rsp_kind == KIND_DEND)
      else $error("name error on a token other than a definition end");

   // nothing waits on the result side right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> rsp_empty)
      else $error("result present straight after reset");

endmodule

// ===== tb/tb_regex_pattern_tokenizer_core.sv =====
module tb_regex_pattern_tokenizer_core;
   import rpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 16;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_Q_LOW   = 8'h71;

   typedef struct {
      logic [2:0]  kind;
      logic [63:0] value;
      logic [1:0]  word_index;
      logic        last;
      logic [2:0]  error_code;
   } token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_ch = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_kind;
   logic [63:0] rsp_value;
   logic [1:0]  rsp_word_index;
   logic        rsp_last;
   logic [2:0]  rsp_error_code;

   // tokenizer state as the predictor sees it
   logic [3:0]  lex_state;
   logic [63:0] member_map [4];
   logic [1:0]  member_total;
   logic [7:0]  first_member;
   logic [2:0]  class_fault;

   token_type   byte_tokens [$];
   token_type   pending_tokens [$];
   int          fail_count = 0;
   int          bytes_sent = 0;
   int          idle_run = 0;
   int          send_idle_pct = 0;
   int          pop_stall_pct = 0;

   regex_pattern_tokenizer_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_ch         (req_ch),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last),
      .rsp_error_code (rsp_error_code)
   );

   always #2 clock = ~clock;

   function automatic bit is_name_byte(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_A_LOW && c <= CH_LOWER_Z) ||
             (c >= CH_ZERO && c <= CH_NINE) || c == CH_UNDERLINE;
   endfunction

   function void add_token(input logic [2:0] kind, input logic [63:0] value,
                           input logic [1:0] word_index, input logic [2:0] error_code);
      token_type t;
      t.kind = kind;
      t.value = value;
      t.word_index = word_index;
      t.last = 1'b0;
      t.error_code = error_code;
      byte_tokens.push_back(t);
   endfunction

   function void join_member(input logic [7:0] b);
      if (member_map[b[7:6]][b[5:0]])
         return;
      member_map[b[7:6]][b[5:0]] = 1'b1;
      if (member_total == 2'd0)
         first_member = b;
      if (member_total < 2'd2)
         member_total = member_total + 2'd1;
   endfunction

   function void note_fault(input logic [2:0] e);
      if (class_fault == ERR_NONE)
         class_fault = e;
   endfunction

   function void add_class_words();
      for (int i = 0; i < 4; i++)
         add_token(KIND_WORD, member_map[i], 2'(i), class_fault);
   endfunction

   function void top_level_byte(input logic [7:0] c);
      lex_state = MODE_TOP;
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_NUL) begin
         add_token(KIND_SEP, CH_DOLLAR, 2'd0, ERR_NONE);
      end else if (c == CH_QUOTE) begin
         lex_state = MODE_STR;
      end else if (c == CH_LBRACKET) begin
         for (int i = 0; i < 4; i++)
            member_map[i] = '0;
         member_total = 2'd0;
         class_fault = ERR_NONE;
         lex_state = MODE_CLS;
      end else if (c == CH_LBRACE) begin
         lex_state = MODE_NAME;
      end else if (c == CH_BACKSLASH) begin
         lex_state = MODE_ESC;
      end else begin
         add_token(KIND_CHAR, c, 2'd0, ERR_NONE);
      end
   endfunction

   function void close_class_at_end();
      add_class_words();
      top_level_byte(CH_NUL);
   endfunction

   function void class_byte(input logic [7:0] c);
      if (c == CH_BACKSLASH)
         lex_state = MODE_CLS_ESC;
      else
         join_member(c);
   endfunction

   function void predict_tokens(input logic [7:0] c);
      logic [8:0] decoded;
      byte_tokens.delete();
      case (lex_state)
         MODE_ESC: begin
            lex_state = MODE_TOP;
            add_token(KIND_SYM, c, 2'd0, ERR_NONE);
         end
         MODE_STR: begin
            if (c == CH_NUL) begin
               add_token(KIND_SEND, '0, 2'd0, ERR_NONE);
               top_level_byte(CH_NUL);
            end else if (c == CH_QUOTE) begin
               add_token(KIND_SEND, '0, 2'd0, ERR_NONE);
               lex_state = MODE_TOP;
            end else if (c == CH_BACKSLASH) begin
               lex_state = MODE_STR_ESC;
            end else begin
               add_token(KIND_SCHAR, c, 2'd0, ERR_NONE);
            end
         end
         MODE_STR_ESC: begin
            if (c == CH_NUL) begin
               add_token(KIND_SEND, '0, 2'd0, ERR_NONE);
               top_level_byte(CH_NUL);
            end else begin
               lex_state = MODE_STR;
               case (c)
                  CH_N_LOW:     decoded = {1'b1, CH_LF};
                  CH_R_LOW:     decoded = {1'b1, CH_CR};
                  CH_ZERO:      decoded = {1'b1, CH_NUL};
                  CH_T_LOW:     decoded = {1'b1, CH_TAB};
                  CH_V_LOW:     decoded = {1'b1, CH_VT};
                  CH_B_LOW:     decoded = {1'b1, CH_BS};
                  CH_F_LOW:     decoded = {1'b1, CH_FF};
                  CH_A_LOW:     decoded = {1'b1, CH_BEL};
                  CH_QUOTE, CH_APOS, CH_BACKSLASH, CH_QUESTION: decoded = {1'b1, c};
                  default:      decoded = '0;
               endcase
               if (decoded[8])
                  add_token(KIND_SCHAR, decoded[7:0], 2'd0, ERR_NONE);
            end
         end
         MODE_CLS: begin
            if (c == CH_NUL) begin
               close_class_at_end();
            end else if (c == CH_RBRACKET) begin
               add_class_words();
               lex_state = MODE_TOP;
            end else if (c == CH_DASH) begin
               if (member_total != 2'd1) begin
                  note_fault(ERR_NO_SINGLE);
                  join_member(CH_DASH);
               end else begin
                  lex_state = MODE_RNG_HIGH;
               end
            end else begin
               class_byte(c);
            end
         end
         MODE_CLS_ESC: begin
            if (c == CH_NUL) begin
               close_class_at_end();
            end else begin
               lex_state = MODE_CLS;
               case (c)
                  CH_N_LOW: join_member(CH_LF);
                  CH_R_LOW: join_member(CH_CR);
                  CH_ZERO:  join_member(CH_NUL);
                  CH_T_LOW: join_member(CH_TAB);
                  CH_V_LOW: join_member(CH_VT);
                  CH_F_LOW: join_member(CH_FF);
                  default:  join_member(c);
               endcase
            end
         end
         MODE_RNG_HIGH: begin
            if (c == CH_NUL) begin
               close_class_at_end();
            end else begin
               if (c > first_member) begin
                  for (int d = int'(first_member) + 1; d <= int'(c); d++)
                     join_member(8'(d));
               end else begin
                  note_fault(ERR_NOT_ABOVE);
               end
               lex_state = MODE_RNG_AFTER;
            end
         end
         MODE_RNG_AFTER: begin
            if (c == CH_RBRACKET) begin
               add_class_words();
               lex_state = MODE_TOP;
            end else if (c == CH_NUL) begin
               note_fault(ERR_NOT_CLOSED);
               close_class_at_end();
            end else begin
               note_fault(ERR_NOT_CLOSED);
               lex_state = MODE_CLS;
               class_byte(c);
            end
         end
         MODE_NAME: begin
            if (is_name_byte(c)) begin
               add_token(KIND_NCHAR, c, 2'd0, ERR_NONE);
            end else if (c == CH_RBRACE) begin
               add_token(KIND_DEND, '0, 2'd0, ERR_NONE);
               lex_state = MODE_TOP;
            end else begin
               add_token(KIND_DEND, '0, 2'd0, ERR_NAME_OPEN);
               top_level_byte(c);
            end
         end
         default: top_level_byte(c);
      endcase
      if (byte_tokens.size() > 0)
         byte_tokens[byte_tokens.size() - 1].last = 1'b1;
      foreach (byte_tokens[i])
         pending_tokens.push_back(byte_tokens[i]);
   endfunction

   // called at a falling edge, returns at a falling edge with the request still up
   task send_byte(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_ch = c;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      predict_tokens(c);
      bytes_sent++;
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);

   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_tokens.size() == 0) begin
            $error("unexpected token: kind %0d value %h", rsp_kind, rsp_value);
            fail_count++;
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind mismatch: expected %0d, actual %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_value !== want.value) begin
               $error("value mismatch: expected %h, actual %h", want.value, rsp_value);
               fail_count++;
            end
            if (rsp_word_index !== want.word_index) begin
               $error("word_index mismatch: expected %0d, actual %0d", want.word_index,
                      rsp_word_index);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
               fail_count++;
            end
            if (rsp_error_code !== want.error_code) begin
               $error("error_code mismatch: expected %0d, actual %0d", want.error_code,
                      rsp_error_code);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_run <= 0;
      else
         idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task test_top_level();
      send_byte(CH_UPPER_A);
      send_byte(8'hFF);
      send_byte(CH_TAB);
      send_byte(CH_BACKSLASH);
      send_byte(CH_LBRACKET);
      send_byte(CH_BACKSLASH);
      send_byte(CH_NUL);
   endtask

   task test_strings();
      send_byte(CH_QUOTE);
      send_byte(CH_BACKSLASH);
      send_byte(CH_N_LOW);
      send_byte(CH_BACKSLASH);
      send_byte(CH_Q_LOW);
      send_byte(CH_QUOTE);
      send_byte(CH_QUOTE);
      send_byte(CH_NUL);
   endtask

   task test_classes();
      // range, then an escape right after it
      send_byte(CH_LBRACKET);
      send_byte(CH_A_LOW);
      send_byte(CH_DASH);
      send_byte(CH_LOWER_Z);
      send_byte(CH_BACKSLASH);
      send_byte(CH_N_LOW);
      send_byte(CH_RBRACKET);
      // falling range, input ends inside the class
      send_byte(CH_LBRACKET);
      send_byte(CH_LOWER_Z);
      send_byte(CH_DASH);
      send_byte(CH_A_LOW);
      send_byte(CH_NUL);
      // dash with no single member
      send_byte(CH_LBRACKET);
      send_byte(CH_DASH);
      send_byte(CH_RBRACKET);
   endtask

   task test_names();
      send_byte(CH_LBRACE);
      send_byte(CH_UNDERLINE);
      send_byte(CH_RBRACE);
      send_byte(CH_LBRACE);
      send_byte(CH_PLUS);
   endtask

   task test_random(input int count);
      int   start;
      int   n;
      logic [7:0] b;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         case ($urandom_range(9))
            0: send_byte(8'($urandom_range(255)));
            1: begin
               send_byte(CH_BACKSLASH);
               send_byte(8'($urandom_range(255)));
            end
            2, 3: begin
               send_byte(CH_QUOTE);
               n = $urandom_range(5);
               repeat (n) begin
                  if ($urandom_range(2) == 0) begin
                     send_byte(CH_BACKSLASH);
                     send_byte(8'($urandom_range(1, 255)));
                  end else begin
                     b = 8'($urandom_range(1, 255));
                     if (b == CH_QUOTE || b == CH_BACKSLASH)
                        b = CH_A_LOW;
                     send_byte(b);
                  end
               end
               send_byte(($urandom_range(9) == 0) ? CH_NUL : CH_QUOTE);
            end
            4, 5, 6: begin
               send_byte(CH_LBRACKET);
               n = $urandom_range(4);
               repeat (n) begin
                  case ($urandom_range(3))
                     0: begin
                        b = 8'($urandom_range(1, 255));
                        send_byte((b == CH_RBRACKET) ? CH_UPPER_A : b);
                     end
                     1: begin
                        b = 8'($urandom_range(1, 255));
                        send_byte((b == CH_RBRACKET || b == CH_BACKSLASH) ? CH_ZERO : b);
                        send_byte(CH_DASH);
                        b = 8'($urandom_range(1, 255));
                        send_byte(b);
                     end
                     2: begin
                        send_byte(CH_BACKSLASH);
                        send_byte(8'($urandom_range(1, 255)));
                     end
                     default: send_byte(CH_DASH);
                  endcase
               end
               send_byte(($urandom_range(9) == 0) ? CH_NUL : CH_RBRACKET);
            end
            7, 8: begin
               send_byte(CH_LBRACE);
               n = $urandom_range(4);
               repeat (n) begin
                  do
                     b = 8'($urandom_range(255));
                  while (!is_name_byte(b));
                  send_byte(b);
               end
               send_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CH_RBRACE);
            end
            default: begin
               case ($urandom_range(3))
                  0: send_byte(CH_SPACE);
                  1: send_byte(CH_TAB);
                  2: send_byte(CH_LF);
                  default: send_byte(CH_NUL);
               endcase
            end
         endcase
      end
   endtask

   initial begin
      lex_state = MODE_TOP;
      for (int i = 0; i < 4; i++)
         member_map[i] = '0;
      member_total = 2'd0;
      first_member = 8'h00;
      class_fault = ERR_NONE;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 15;
      pop_stall_pct = 81;
      test_top_level();
      test_strings();
      test_classes();
      test_names();
      test_random(45);

      send_idle_pct = 81;
      pop_stall_pct = 15;
      test_random(45);

      send_idle_pct = 0;
      pop_stall_pct = 0;
      test_random(45);

      req_push = 1'b0;
      while (pending_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/rpt_pkg.sv
sv/rpt_front.sv
sv/rpt_queue.sv
sv/rpt_back.sv
sv/regex_pattern_tokenizer_core.sv
tb/tb_regex_pattern_tokenizer_core.sv
